FILE: rtl/core/bqf_pkg.sv
`timescale 1ns / 1ps

package bqf_pkg;

  localparam int BQF_SAMPLE_WIDTH = 24;
  localparam int BQF_COEF_WIDTH   = 32;

  localparam int BQF_NUM_REGS  = 5;
  localparam int BQF_CFG_IDX_W = 3;
  localparam int BQF_PC_W      = 4;

  // Configuration register indexes, also used to pick a multiplier coefficient.
  typedef enum logic [BQF_CFG_IDX_W-1:0] {
    REG_FB1 = 3'd0,
    REG_FB2 = 3'd1,
    REG_FF0 = 3'd2,
    REG_FF1 = 3'd3,
    REG_FF2 = 3'd4
  } reg_idx_t;

  // Second multiplier operand.
  typedef enum logic [1:0] {
    B_NODE_PREV  = 2'd0,
    B_NODE_PREV2 = 2'd1,
    B_NODE_NEW   = 2'd2,
    B_FB1        = 2'd3
  } bsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_LOAD = 2'd2
  } acc_op_t;

  typedef struct packed {
    reg_idx_t              coef_sel;
    bsel_t                 b_sel;
    acc_op_t               acc_op;
    logic                  node_wr;
    logic                  out_wr;
    logic                  out_zero;
    logic                  jmp_unstable;
    logic [BQF_PC_W-1:0]   jmp_addr;
    logic                  done;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    coef_sel:     REG_FB1,
    b_sel:        B_NODE_PREV,
    acc_op:       ACC_HOLD,
    node_wr:      1'b0,
    out_wr:       1'b0,
    out_zero:     1'b0,
    jmp_unstable: 1'b0,
    jmp_addr:     '0,
    done:         1'b0
  };

endpackage

FILE: rtl/core/bqf_seq.sv
`timescale 1ns / 1ps

module bqf_seq
  import bqf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_full,
  input  logic  unstable,
  output logic  busy,
  output ctrl_t ctrl
);

  localparam logic [BQF_PC_W-1:0] STEP_SQUARE   = 4'd0;
  localparam logic [BQF_PC_W-1:0] STEP_CHECK    = 4'd1;
  localparam logic [BQF_PC_W-1:0] STEP_FB2      = 4'd2;
  localparam logic [BQF_PC_W-1:0] STEP_FF1      = 4'd3;
  localparam logic [BQF_PC_W-1:0] STEP_NODE     = 4'd4;
  localparam logic [BQF_PC_W-1:0] STEP_FF0      = 4'd5;
  localparam logic [BQF_PC_W-1:0] STEP_SUM      = 4'd6;
  localparam logic [BQF_PC_W-1:0] STEP_OUT      = 4'd7;
  localparam logic [BQF_PC_W-1:0] STEP_BYPASS   = 4'd8;
  localparam logic [BQF_PC_W-1:0] STEP_ZERO_OUT = 4'd9;

  logic [BQF_PC_W-1:0] pc;
  ctrl_t               word;

  // Stable path: each product but fb1 squared is added next step.
  function automatic ctrl_t ucode(input logic [BQF_PC_W-1:0] addr);
    ctrl_t w;
    w = CTRL_NOP;
    case (addr)
      STEP_SQUARE: begin
        w.coef_sel = REG_FB1;
        w.b_sel    = B_FB1;
      end
      STEP_CHECK: begin
        w.jmp_unstable = 1'b1;
        w.jmp_addr     = STEP_BYPASS;
        w.coef_sel     = REG_FB1;
        w.b_sel        = B_NODE_PREV;
      end
      STEP_FB2: begin
        w.acc_op   = ACC_ADD;
        w.coef_sel = REG_FB2;
        w.b_sel    = B_NODE_PREV2;
      end
      STEP_FF1: begin
        w.acc_op   = ACC_ADD;
        w.coef_sel = REG_FF1;
        w.b_sel    = B_NODE_PREV;
      end
      STEP_NODE: begin
        w.node_wr  = 1'b1;
        w.acc_op   = ACC_LOAD;
        w.coef_sel = REG_FF2;
        w.b_sel    = B_NODE_PREV2;
      end
      STEP_FF0: begin
        w.acc_op   = ACC_ADD;
        w.coef_sel = REG_FF0;
        w.b_sel    = B_NODE_NEW;
      end
      STEP_SUM: begin
        w.acc_op = ACC_ADD;
      end
      STEP_OUT: begin
        w.out_wr = 1'b1;
        w.done   = 1'b1;
      end
      STEP_BYPASS: begin
        w.node_wr = 1'b1;
      end
      STEP_ZERO_OUT: begin
        w.out_wr   = 1'b1;
        w.out_zero = 1'b1;
        w.done     = 1'b1;
      end
      default: begin
        w = CTRL_NOP;
      end
    endcase
    return w;
  endfunction

  assign word = ucode(pc);

  // The final step waits while the previous result has not been taken.
  always_comb begin
    if (busy && !(word.done && out_full)) begin
      ctrl = word;
    end else begin
      ctrl = CTRL_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= STEP_SQUARE;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= STEP_SQUARE;
    end else if (busy && !(word.done && out_full)) begin
      if (ctrl.done) begin
        busy <= 1'b0;
      end
      if (ctrl.jmp_unstable && unstable) begin
        pc <= ctrl.jmp_addr;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/bqf_datapath.sv
`timescale 1ns / 1ps

module bqf_datapath
  import bqf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = BQF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = BQF_COEF_WIDTH
)
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [BQF_CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data,
  input  logic                           load,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  ctrl_t                          ctrl,
  output logic                           unstable,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int NW = SAMPLE_WIDTH + 8;
  localparam int CW = COEF_WIDTH;
  localparam int CF = COEF_WIDTH - 4;
  localparam int BW = (NW > CW) ? NW : CW;
  localparam int PW = CW + BW;
  localparam int AW = NW + 5;
  localparam int DW = CW + 4;

  localparam logic signed [CW-1:0]   NEG_ONE = {4'b1111, {CF{1'b0}}};
  localparam logic signed [CW-1:0]   TWO     = {3'b001, {(CW-3){1'b0}}};
  localparam logic signed [CW-1:0]   NEG_TWO = {3'b111, {(CW-3){1'b0}}};
  localparam logic signed [CW+1:0]   ONE_X   = {6'b000001, {CF{1'b0}}};

  logic signed [CW-1:0] coef [BQF_NUM_REGS];

  logic signed [NW-1:0] node_prev;
  logic signed [NW-1:0] node_prev2;
  logic signed [NW-1:0] node_new;
  logic signed [NW-1:0] node_sat;

  logic signed [CW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;
  logic signed [AW-1:0] prod_term;
  logic signed [AW-1:0] acc;
  logic signed [SAMPLE_WIDTH:0] x_aligned;

  logic signed [CW-1:0] fb1;
  logic signed [CW-1:0] fb2;
  logic signed [DW-1:0] disc;
  logic signed [CW+1:0] a_x;
  logic signed [CW+1:0] b_x;
  logic signed [CW+1:0] lo_margin;
  logic signed [CW+1:0] hi_margin;
  logic                 stable;
  logic signed [SAMPLE_WIDTH-1:0] out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BQF_NUM_REGS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_write && (cfg_index < BQF_CFG_IDX_W'(BQF_NUM_REGS))) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // Operand selection for the single shared multiplier.
  assign mul_a = coef[ctrl.coef_sel];

  always_comb begin
    case (ctrl.b_sel)
      B_NODE_PREV:  mul_b = BW'(node_prev);
      B_NODE_PREV2: mul_b = BW'(node_prev2);
      B_NODE_NEW:   mul_b = BW'(node_new);
      B_FB1:        mul_b = BW'(coef[REG_FB1]);
      default:      mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  // Arithmetic right shift rounds toward minus infinity.
  assign prod_sh   = prod >>> CF;
  assign prod_term = prod_sh[AW-1:0];

  assign x_aligned = {sample_in, 1'b0};

  always_ff @(posedge clk) begin
    if (load) begin
      acc <= AW'(x_aligned);
    end else begin
      case (ctrl.acc_op)
        ACC_ADD:  acc <= acc + prod_term;
        ACC_LOAD: acc <= prod_term;
        default:  acc <= acc;
      endcase
    end
  end

  always_comb begin
    if ((&acc[AW-1:NW-1]) || !(|acc[AW-1:NW-1])) begin
      node_sat = acc[NW-1:0];
    end else begin
      node_sat = acc[AW-1] ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.node_wr) begin
      node_new <= node_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_prev  <= '0;
      node_prev2 <= '0;
    end else if (ctrl.done) begin
      node_prev2 <= node_prev;
      node_prev  <= node_new;
    end
  end

  // Stability test on the feedback pair; the square of fb1 sits in prod
  // during the check step.
  assign fb1       = coef[REG_FB1];
  assign fb2       = coef[REG_FB2];
  assign disc      = prod_sh[DW-1:0] + {{2{fb2[CW-1]}}, fb2, 2'b00};
  assign a_x       = {{2{fb1[CW-1]}}, fb1};
  assign b_x       = {{2{fb2[CW-1]}}, fb2};
  assign lo_margin = ONE_X - a_x - b_x;
  assign hi_margin = ONE_X + a_x - b_x;

  always_comb begin
    if (disc[DW-1]) begin
      stable = (fb2 >= NEG_ONE);
    end else begin
      stable = (fb1 <= TWO) && (fb1 >= NEG_TWO) && !lo_margin[CW+1] && !hi_margin[CW+1];
    end
  end

  assign unstable = !stable;

  always_comb begin
    if ((&acc[AW-1:SAMPLE_WIDTH]) || !(|acc[AW-1:SAMPLE_WIDTH])) begin
      out_sat = acc[SAMPLE_WIDTH:1];
    end else begin
      out_sat = acc[AW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                          : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  assign result = ctrl.out_zero ? '0 : out_sat;

endmodule

FILE: rtl/core/biquad_iir_filter_top.sv
`timescale 1ns / 1ps
// The result register loads at the output step, or at the zero-output step when the
// feedback pair fails the stability test (output forced to zero). Samples are taken
// one at a time: a new sample is accepted only once the microcode program driving
// the one shared multiplier has finished, including any wait of its final step for a
// held-off result. Reset: coefficients and node history cleared, sequencer idle, no
// result pending.

module biquad_iir_filter_top
  import bqf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = BQF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = BQF_COEF_WIDTH
)
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input  logic                           cfg_write,
  input  logic [BQF_CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data
);

  logic                           busy;
  logic                           accept;
  logic                           unstable;
  logic signed [SAMPLE_WIDTH-1:0] result;
  ctrl_t                          ctrl;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  bqf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_full (out_valid && out_stall),
    .unstable (unstable),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  bqf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load      (accept),
    .sample_in (sample_in),
    .ctrl      (ctrl),
    .unstable  (unstable),
    .result    (result)
  );

  // Output register: holds a finished transaction while the next sample is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_wr) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_wr) begin
      sample_out <= result;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_wr |-> !(out_valid && out_stall))
    else $error("result register overwritten while a transaction is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("sequencer did not start after an accepted transaction");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.out_wr))
    else $error("output valid raised without a result write");

  a_unstable_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_wr && ctrl.out_zero) |=> (sample_out == '0))
    else $error("unstable feedback gave a non-zero output");
`endif

endmodule

FILE: verif/tb_biquad_iir_filter_top.sv
`timescale 1ns / 1ps

module tb_biquad_iir_filter_top;
  import bqf_pkg::*;

  localparam int SW = BQF_SAMPLE_WIDTH;
  localparam int CW = BQF_COEF_WIDTH;
  localparam int NW = SW + 8;
  localparam int COEF_ONE = 1 << (CW - 4);
  localparam int RANDOM_ITEMS = 1025;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 20;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [79:0] wide_t;
  typedef enum int {SRC_NOISE, SRC_QUIET, SRC_DC, SRC_TOGGLE} sample_src_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SW-1:0]     sample_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SW-1:0]     sample_out;
  logic                     cfg_write = 1'b0;
  logic [BQF_CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]            cfg_data = '0;

  // Filter state as the testbench sees it.
  logic signed [CW-1:0] coef_bank [BQF_NUM_REGS];
  logic signed [NW-1:0] node_hist1 = '0;
  logic signed [NW-1:0] node_hist2 = '0;

  logic signed [SW-1:0] samples_to_send [$];
  logic signed [SW-1:0] predicted_samples [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_requests = 0;
  int hold_off_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int samples_accepted = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int unstable_samples = 0;
  int node_clips = 0;
  int output_clips = 0;
  int settings_used = 0;

  int fb1_edges [7] = '{-2 * COEF_ONE - 1, -2 * COEF_ONE, -COEF_ONE, 0, COEF_ONE,
                        2 * COEF_ONE, 2 * COEF_ONE + 1};
  int fb2_edges [5] = '{-COEF_ONE - 1, -COEF_ONE, 0, COEF_ONE, COEF_ONE + 1};

  biquad_iir_filter_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact product of a coefficient and a node value, floored to node precision.
  function automatic wide_t scaled_product(input logic signed [CW-1:0] coef,
                                           input logic signed [NW-1:0] node);
    wide_t coef_x, node_x;
    coef_x = wide_t'(coef);
    node_x = wide_t'(node);
    return (coef_x * node_x) >>> (CW - 4);
  endfunction

  function automatic wide_t clamp_to(input wide_t v, input int bits);
    wide_t top;
    top = 1;
    top = (top <<< (bits - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic bit feedback_stable(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
    wide_t ax, bx, one;
    ax = wide_t'(a);
    bx = wide_t'(b);
    one = COEF_ONE;
    // Complex poles only need the second coefficient bounded.
    if (((ax * ax) >>> (CW - 4)) + 4 * bx < 0) return bx >= -one;
    return ax <= 2 * one && ax >= -2 * one && one - ax - bx >= 0 && one + ax - bx >= 0;
  endfunction

  function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
    logic signed [CW-1:0] c [BQF_NUM_REGS];
    wide_t node_sum, node_sat, out_sum, out_sat;
    bit stable;
    stable = feedback_stable(coef_bank[REG_FB1], coef_bank[REG_FB2]);
    for (int i = 0; i < BQF_NUM_REGS; i++) c[i] = stable ? coef_bank[i] : '0;
    if (!stable) unstable_samples++;
    node_sum = wide_t'(x);
    node_sum = node_sum * 2 + scaled_product(c[REG_FB1], node_hist1)
             + scaled_product(c[REG_FB2], node_hist2);
    node_sat = clamp_to(node_sum, NW);
    if (node_sat != node_sum) node_clips++;
    out_sum = scaled_product(c[REG_FF0], node_sat[NW-1:0])
            + scaled_product(c[REG_FF1], node_hist1)
            + scaled_product(c[REG_FF2], node_hist2);
    out_sum = out_sum >>> 1;
    out_sat = clamp_to(out_sum, SW);
    if (out_sat != out_sum) output_clips++;
    node_hist2 = node_hist1;
    node_hist1 = node_sat[NW-1:0];
    return out_sat[SW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] pick_forward();
    case ($urandom_range(0, 7))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2, 3, 4: return $urandom;
      default: return int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
    endcase
  endfunction

  function automatic logic signed [SW-1:0] make_sample(input sample_src_t src, input int n,
                                                       input logic signed [SW-1:0] level);
    logic signed [SW-1:0] v;
    v = SW'($urandom);
    case (src)
      SRC_NOISE: return v;
      SRC_QUIET: return v >>> $urandom_range(1, SW - 1);
      SRC_DC:    return level;
      default:   return n[0] ? ~level : level;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
  endtask

  task automatic write_register(input logic [BQF_CFG_IDX_W-1:0] idx,
                                input logic [CW-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx < BQF_NUM_REGS) coef_bank[idx] = value;
  endtask

  task automatic load_coefficients(input logic signed [CW-1:0] fb1,
                                   input logic signed [CW-1:0] fb2,
                                   input logic signed [CW-1:0] ff0,
                                   input logic signed [CW-1:0] ff1,
                                   input logic signed [CW-1:0] ff2);
    write_register(REG_FB1, fb1);
    write_register(REG_FB2, fb2);
    write_register(REG_FF0, ff0);
    write_register(REG_FF1, ff1);
    write_register(REG_FF2, ff2);
    settings_used++;
    @(negedge clk);
  endtask

  // Returns at a falling edge once every sample has gone through and the block is quiet.
  task automatic wait_for_drain();
    @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || predicted_samples.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: queued samples are offered with random idle gaps, each held until the block accepts it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_samples.push_back(filter_sample(sample_in));
        samples_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          sample_in <= samples_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each completed output transaction and drives the receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_samples.size() == 0) begin
          report_mismatch($sformatf("sample_out %0d arrived with no sample pending", sample_out));
        end else begin
          results_checked++;
          if (sample_out !== predicted_samples[0])
            report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                      results_checked, sample_out, predicted_samples[0]));
          void'(predicted_samples.pop_front());
        end
      end
      if (hold_off_served != hold_off_requests) begin
        hold_off_served <= hold_off_requests;
        hold_left <= HOLD_OFF_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, predicted_samples.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int phase, len, a, b, span, random_sent;
    logic signed [CW-1:0] fb1, fb2;
    logic signed [SW-1:0] level;
    sample_src_t src;

    for (int i = 0; i < BQF_NUM_REGS; i++) coef_bank[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Coefficients straight out of reset: the output stays at zero while the nodes fill.
    samples_to_send.push_back(SAMPLE_MAX);
    samples_to_send.push_back(SAMPLE_MIN);
    samples_to_send.push_back('0);
    wait_for_drain();

    // Unity gain on the current node only.
    load_coefficients(0, 0, COEF_ONE, 0, 0);
    samples_to_send.push_back(SAMPLE_MAX);
    samples_to_send.push_back(SAMPLE_MIN);
    samples_to_send.push_back('1);
    samples_to_send.push_back(SW'(1));
    samples_to_send.push_back({(SW/2){2'b01}});
    wait_for_drain();

    // Extreme feedforward gains drive the output into both clipping limits.
    load_coefficients(0, 0, COEF_MAX, COEF_MIN, COEF_MAX);
    samples_to_send.push_back(SAMPLE_MAX);
    samples_to_send.push_back(SAMPLE_MIN);
    samples_to_send.push_back(SAMPLE_MAX);
    samples_to_send.push_back('0);
    wait_for_drain();

    // Writes beyond the register list must leave the bank untouched.
    for (int k = 0; k < 3; k++) write_register(BQF_CFG_IDX_W'(BQF_NUM_REGS + k), $urandom);
    // Second feedback coefficient just past minus one: everything reads as zero.
    load_coefficients(COEF_ONE, -COEF_ONE - 1, COEF_ONE, COEF_ONE, COEF_ONE);
    samples_to_send.push_back(SAMPLE_MIN);
    samples_to_send.push_back(SAMPLE_MAX);
    samples_to_send.push_back(SW'(1));
    wait_for_drain();

    // Exactly minus one is still accepted as stable.
    load_coefficients(COEF_ONE, -COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE);
    samples_to_send.push_back({(SW/2){2'b10}});
    samples_to_send.push_back('1);
    samples_to_send.push_back(SAMPLE_MAX);
    wait_for_drain();

    // Double pole at DC on the stability boundary lets the nodes grow.
    load_coefficients(2 * COEF_ONE, -COEF_ONE, COEF_ONE / 16, 0, 0);
    for (int n = 0; n < 7; n++) samples_to_send.push_back(SAMPLE_MAX);

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_for_drain();
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 25;
        recv_stall_pct = 51;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      case ($urandom_range(0, 9))
        0, 1: begin
          fb1 = $urandom;
          fb2 = $urandom;
        end
        2: begin
          fb1 = 2 * COEF_ONE;
          fb2 = -COEF_ONE;
        end
        3, 4: begin
          fb1 = fb1_edges[$urandom_range(0, 6)];
          fb2 = fb2_edges[$urandom_range(0, 4)];
        end
        default: begin
          // Any point inside the stability triangle.
          b = int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
          span = COEF_ONE - b;
          a = int'($urandom_range(0, 2 * span)) - span;
          fb1 = a;
          fb2 = b;
        end
      endcase
      if ($urandom_range(0, 3) == 0)
        write_register(BQF_CFG_IDX_W'(BQF_NUM_REGS + $urandom_range(0, 2)), $urandom);
      load_coefficients(fb1, fb2, pick_forward(), pick_forward(), pick_forward());

      src = sample_src_t'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0: level = SAMPLE_MAX;
        1: level = SAMPLE_MIN;
        default: level = SW'($urandom);
      endcase
      len = $urandom_range(20, 80);
      for (int n = 0; n < len; n++) samples_to_send.push_back(make_sample(src, n, level));
      random_sent += len;
      // Hold the output back long enough for the input side to back up.
      if (phase == 2) hold_off_requests++;
      phase++;
    end
    wait_for_drain();

    $display("Filtered %0d samples over %0d coefficient settings, %0d of them unstable.",
             samples_accepted, settings_used, unstable_samples);
    $display("Nodes clipped %0d times and outputs %0d times; %0d results checked.",
             node_clips, output_clips, results_checked);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
